// ===== rtl/bdlpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdlpe_pkg;

    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int RAW_W        = 8;
    localparam int MASK_W       = 8;
    localparam int EVT_BUTTON_W = 3;
    localparam int QUEUE_FILL_W = 5;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 2'd1;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_POLL = 1'b1;

    typedef enum logic [1:0] {
        KIND_PRESSED  = 2'd0,
        KIND_RELEASED = 2'd1,
        KIND_SHORT    = 2'd2,
        KIND_LONG     = 2'd3
    } kind_t;

    typedef struct packed {
        logic  first_valid;
        kind_t first_kind;
        logic  second_valid;
        kind_t second_kind;
    } lane_evt_t;

    typedef struct packed {
        logic [EVT_BUTTON_W-1:0] button;
        kind_t                   kind;
        logic [TIME_W-1:0]       time_ms;
    } evt_entry_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        evt_entry_t data;
    } queue_req_t;

endpackage

`default_nettype wire

// ===== rtl/bdlpe_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdlpe_lane
    import bdlpe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tick_en,
    input  wire logic              raw_in,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic [CFG_W-1:0]  debounce_time,
    input  wire logic [CFG_W-1:0]  long_press_time,
    output logic                   stable,
    output lane_evt_t              evt
);

    logic              raw_reg, raw_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic              stable_reg, stable_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic              fired_reg, fired_next;
    lane_evt_t         evt_reg, evt_next;

    logic              changed;
    logic [TIME_W-1:0] elapsed_db;
    logic [TIME_W-1:0] elapsed_lp;
    logic              flip;
    logic              press;
    logic              release_ev;
    logic              fired_mid;
    logic              long_ev;

    always_comb
    begin
        changed    = (raw_in != raw_reg);
        raw_next   = raw_in;
        last_next  = changed ? now_ms : last_reg;
        elapsed_db = changed ? '0 : (now_ms - last_reg);
        flip       = (elapsed_db >= TIME_W'(debounce_time)) && (stable_reg != raw_in);
        press      = flip && raw_in;
        release_ev = flip && !raw_in;
        stable_next = flip ? raw_in : stable_reg;
        start_next = press ? now_ms : start_reg;
        fired_mid  = press ? 1'b0 : fired_reg;
        elapsed_lp = press ? '0 : (now_ms - start_reg);
        long_ev    = stable_next && !fired_mid && (elapsed_lp >= TIME_W'(long_press_time));
        fired_next = long_ev ? 1'b1 : fired_mid;

        evt_next = '0;
        if (press)
        begin
            evt_next.first_valid  = 1'b1;
            evt_next.first_kind   = KIND_PRESSED;
            evt_next.second_valid = long_ev;
            evt_next.second_kind  = KIND_LONG;
        end
        else if (release_ev)
        begin
            evt_next.first_valid  = 1'b1;
            evt_next.first_kind   = KIND_RELEASED;
            evt_next.second_valid = !fired_reg;
            evt_next.second_kind  = KIND_SHORT;
        end
        else if (long_ev)
        begin
            evt_next.first_valid = 1'b1;
            evt_next.first_kind  = KIND_LONG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= 1'b0;
            last_reg   <= '0;
            stable_reg <= 1'b0;
            start_reg  <= '0;
            fired_reg  <= 1'b0;
            evt_reg    <= '0;
        end
        else if (tick_en)
        begin
            raw_reg    <= raw_next;
            last_reg   <= last_next;
            stable_reg <= stable_next;
            start_reg  <= start_next;
            fired_reg  <= fired_next;
            evt_reg    <= evt_next;
        end
    end

    assign stable = stable_reg;
    assign evt    = evt_reg;

endmodule

`default_nettype wire

// ===== rtl/bdlpe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdlpe_queue
    import bdlpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire queue_req_t                        req,
    output evt_entry_t                             rd_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    evt_entry_t        mem [QUEUE_DEPTH];
    evt_entry_t        rd_data_reg;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              full;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        full        = (count_reg == CNT_FULL);
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (req.push)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            if (full)
            begin
                // oldest entry dropped
                rd_ptr_next = ptr_inc(rd_ptr_reg);
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (req.pop && (count_reg != '0))
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[wr_ptr_reg] <= req.data;
        end
        if (req.pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

`default_nettype wire

// ===== rtl/button_debounce_long_press_events_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                  payload
// input     in         in_valid / in_stall        op, raw_pressed, now_ms
// output    out        out_valid / out_stall      event_valid, event_button, event_kind,
//                                                 event_time, stable_mask, queue_fill
// config    in         cfg_we                     cfg_index, cfg_data
//
// a tick updates all button lanes in parallel as it is taken, then uses one queue write slot
// per button per possible event, then the result beat.
// a poll makes one registered read of the event memory, then the result beat.
// reset clears all button state, the queue pointers and fill; the event memory is not cleared.
// the result sits in an output register, so the next beat is taken while it is stalled.

module button_debounce_long_press_events_unit
    import bdlpe_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    op,
    input  wire logic [RAW_W-1:0]        raw_pressed,
    input  wire logic [TIME_W-1:0]       now_ms,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         event_valid,
    output logic [EVT_BUTTON_W-1:0]      event_button,
    output logic [1:0]                   event_kind,
    output logic [TIME_W-1:0]            event_time,
    output logic [MASK_W-1:0]            stable_mask,
    output logic [QUEUE_FILL_W-1:0]      queue_fill
);

    localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [BTN_W-1:0] BTN_LAST = BTN_W'(NUM_BUTTONS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [BTN_W-1:0]   btn_reg, btn_next;
    logic               half_reg, half_next;
    logic [TIME_W-1:0]  tick_time_reg, tick_time_next;
    logic               hit_reg, hit_next;
    logic [CFG_W-1:0]   debounce_reg;
    logic [CFG_W-1:0]   long_press_reg;

    logic                    out_valid_reg, out_valid_next;
    logic                    event_valid_reg, event_valid_next;
    logic [EVT_BUTTON_W-1:0] event_button_reg, event_button_next;
    logic [1:0]              event_kind_reg, event_kind_next;
    logic [TIME_W-1:0]       event_time_reg, event_time_next;
    logic [MASK_W-1:0]       stable_mask_reg, stable_mask_next;
    logic [QUEUE_FILL_W-1:0] queue_fill_reg, queue_fill_next;

    logic               accept;
    logic               tick_en;
    logic               stable_bits [NUM_BUTTONS];
    lane_evt_t          lane_evt [NUM_BUTTONS];
    logic [MASK_W-1:0]  mask;
    lane_evt_t          sel_evt;
    queue_req_t         qreq;
    evt_entry_t         q_rd_data;
    logic [CNT_W-1:0]   q_count;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign tick_en  = accept && (op == OP_TICK);

    // button lanes
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        logic raw_bit;
        if (i < RAW_W)
        begin : g_raw
            assign raw_bit = raw_pressed[i];
        end
        else
        begin : g_none
            assign raw_bit = 1'b0;
        end

        bdlpe_lane u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .tick_en         (tick_en),
            .raw_in          (raw_bit),
            .now_ms          (now_ms),
            .debounce_time   (debounce_reg),
            .long_press_time (long_press_reg),
            .stable          (stable_bits[i]),
            .evt             (lane_evt[i])
        );
    end

    for (genvar b = 0; b < MASK_W; b++)
    begin : g_mask
        if (b < NUM_BUTTONS)
        begin : g_on
            assign mask[b] = stable_bits[b];
        end
        else
        begin : g_off
            assign mask[b] = 1'b0;
        end
    end

    bdlpe_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (qreq),
        .rd_data (q_rd_data),
        .count   (q_count)
    );

    // merge: one queue slot per cycle, buttons in index order
    always_comb
    begin
        sel_evt = lane_evt[btn_reg];

        qreq              = '0;
        qreq.data.button  = EVT_BUTTON_W'(btn_reg);
        qreq.data.kind    = half_reg ? sel_evt.second_kind : sel_evt.first_kind;
        qreq.data.time_ms = tick_time_reg;

        state_next        = state_reg;
        btn_next          = btn_reg;
        half_next         = half_reg;
        tick_time_next    = tick_time_reg;
        hit_next          = hit_reg;

        out_valid_next    = out_valid_reg && out_stall;
        event_valid_next  = event_valid_reg;
        event_button_next = event_button_reg;
        event_kind_next   = event_kind_reg;
        event_time_next   = event_time_reg;
        stable_mask_next  = stable_mask_reg;
        queue_fill_next   = queue_fill_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    btn_next       = '0;
                    half_next      = 1'b0;
                    tick_time_next = now_ms;
                    if (op == OP_TICK)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        qreq.pop   = (q_count != '0);
                        hit_next   = (q_count != '0);
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                qreq.push = half_reg ? sel_evt.second_valid : sel_evt.first_valid;
                half_next = !half_reg;
                if (half_reg)
                begin
                    btn_next = btn_reg + 1'b1;
                    if (btn_reg == BTN_LAST)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    event_valid_next  = hit_reg;
                    event_button_next = hit_reg ? q_rd_data.button : '0;
                    event_kind_next   = hit_reg ? q_rd_data.kind : 2'd0;
                    event_time_next   = hit_reg ? q_rd_data.time_ms : '0;
                    stable_mask_next  = mask;
                    queue_fill_next   = QUEUE_FILL_W'(q_count);
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            btn_reg        <= '0;
            half_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            btn_reg       <= btn_next;
            half_reg      <= half_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_DEBOUNCE))
            begin
                debounce_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_LONG_PRESS))
            begin
                long_press_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tick_time_reg    <= tick_time_next;
        event_valid_reg  <= event_valid_next;
        event_button_reg <= event_button_next;
        event_kind_reg   <= event_kind_next;
        event_time_reg   <= event_time_next;
        stable_mask_reg  <= stable_mask_next;
        queue_fill_reg   <= queue_fill_next;
    end

    assign out_valid    = out_valid_reg;
    assign event_valid  = event_valid_reg;
    assign event_button = event_button_reg;
    assign event_kind   = event_kind_reg;
    assign event_time   = event_time_reg;
    assign stable_mask  = stable_mask_reg;
    assign queue_fill   = queue_fill_reg;

endmodule

`default_nettype wire

// ===== bench/button_debounce_long_press_events_unit_test.sv =====
`timescale 1ns / 1ps

module button_debounce_long_press_events_unit_test;

    import bdlpe_pkg::*;

    localparam int BUTTONS     = 8;
    localparam int EVENT_SLOTS = 16;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic              op;
        logic [RAW_W-1:0]  raw;
        logic [TIME_W-1:0] now;
    } sample_t;

    typedef struct packed {
        logic                    ev_valid;
        logic [EVT_BUTTON_W-1:0] button;
        kind_t                   kind;
        logic [TIME_W-1:0]       ev_time;
        logic [MASK_W-1:0]       mask;
        logic [QUEUE_FILL_W-1:0] fill;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_DEBOUNCE;
    logic [CFG_W-1:0]       cfg_data = '0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              op = OP_TICK;
    logic [RAW_W-1:0]  raw_pressed = '0;
    logic [TIME_W-1:0] now_ms = '0;

    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    event_valid;
    logic [EVT_BUTTON_W-1:0] event_button;
    logic [1:0]              event_kind;
    logic [TIME_W-1:0]       event_time;
    logic [MASK_W-1:0]       stable_mask;
    logic [QUEUE_FILL_W-1:0] queue_fill;

    button_debounce_long_press_events_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .raw_pressed  (raw_pressed),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_valid  (event_valid),
        .event_button (event_button),
        .event_kind   (event_kind),
        .event_time   (event_time),
        .stable_mask  (stable_mask),
        .queue_fill   (queue_fill)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [CFG_W-1:0]  settle_window = DEBOUNCE_RESET;
    logic [CFG_W-1:0]  hold_window   = LONG_PRESS_RESET;
    logic [BUTTONS-1:0] raw_lvl    = '0;
    logic [BUTTONS-1:0] stable_lvl = '0;
    logic [BUTTONS-1:0] long_done  = '0;
    logic [TIME_W-1:0] changed_at [BUTTONS];
    logic [TIME_W-1:0] press_at [BUTTONS];
    evt_entry_t        ev_store [EVENT_SLOTS];
    logic [3:0]        ev_rd = '0;
    logic [3:0]        ev_wr = '0;
    logic [4:0]        ev_count = '0;

    sample_t     pending_samples [$];
    report_t     due_results [$];
    sample_t     on_wire;
    int unsigned beats_left = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left [2];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    logic [TIME_W-1:0] gen_ms = '0;
    logic [RAW_W-1:0]  hold_raw = '0;

    initial
    begin
        for (int i = 0; i < BUTTONS; i++)
        begin
            changed_at[i] = '0;
            press_at[i] = '0;
        end
        calm_left[0] = 0;
        calm_left[1] = 0;
    end

    function automatic int unsigned next_gap(input int side);
        int unsigned r;
        if (calm_left[side] != 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left[side] = $urandom_range(15, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ring of events, oldest dropped when full
    function automatic void queue_event(input logic [2:0] btn, input kind_t kind,
                                        input logic [TIME_W-1:0] stamp);
        if (ev_count == EVENT_SLOTS)
        begin
            ev_rd++;
            ev_count--;
        end
        ev_store[ev_wr].button = btn;
        ev_store[ev_wr].kind = kind;
        ev_store[ev_wr].time_ms = stamp;
        ev_wr++;
        ev_count++;
    endfunction

    function automatic void debounce_and_queue(input sample_t s);
        report_t           r;
        logic [TIME_W-1:0] held;
        r = '0;
        if (s.op == OP_TICK)
        begin
            for (int i = 0; i < BUTTONS; i++)
            begin
                if (s.raw[i] != raw_lvl[i])
                begin
                    raw_lvl[i] = s.raw[i];
                    changed_at[i] = s.now;
                end
                held = s.now - changed_at[i];
                if (held >= {16'd0, settle_window} && stable_lvl[i] != raw_lvl[i])
                begin
                    stable_lvl[i] = raw_lvl[i];
                    if (stable_lvl[i])
                    begin
                        press_at[i] = s.now;
                        long_done[i] = 1'b0;
                        queue_event(3'(i), KIND_PRESSED, s.now);
                    end
                    else
                    begin
                        queue_event(3'(i), KIND_RELEASED, s.now);
                        if (!long_done[i])
                            queue_event(3'(i), KIND_SHORT, s.now);
                    end
                end
                held = s.now - press_at[i];
                if (stable_lvl[i] && !long_done[i] && held >= {16'd0, hold_window})
                begin
                    long_done[i] = 1'b1;
                    queue_event(3'(i), KIND_LONG, s.now);
                end
            end
        end
        else if (ev_count != 0)
        begin
            r.ev_valid = 1'b1;
            r.button = ev_store[ev_rd].button;
            r.kind = ev_store[ev_rd].kind;
            r.ev_time = ev_store[ev_rd].time_ms;
            ev_rd++;
            ev_count--;
        end
        r.mask = stable_lvl;
        r.fill = ev_count;
        due_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                debounce_and_queue(on_wire);
                beats_left--;
                send_gap = next_gap(0);
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    on_wire = pending_samples.pop_front();
                    op <= on_wire.op;
                    raw_pressed <= on_wire.raw;
                    now_ms <= on_wire.now;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("event_valid", 32'(want.ev_valid), 32'(event_valid));
                    check_field("event_button", 32'(want.button), 32'(event_button));
                    check_field("event_kind", 32'(want.kind), 32'(event_kind));
                    check_field("event_time", want.ev_time, event_time);
                    check_field("stable_mask", 32'(want.mask), 32'(stable_mask));
                    check_field("queue_fill", 32'(want.fill), 32'(queue_fill));
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 2) == 0)
                    stall_left = next_gap(1);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_sample(input logic o, input logic [RAW_W-1:0] raw,
                              input logic [TIME_W-1:0] now);
        sample_t s;
        s.op = o;
        s.raw = raw;
        s.now = now;
        pending_samples.push_back(s);
        beats_left++;
    endtask

    // held patterns with bounce, noise and jumps in time, mixed with random polls
    task automatic add_random(input int n, input int poll_pct, input int step_max,
                              input int jump_max);
        int unsigned r;
        logic [RAW_W-1:0] raw;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < poll_pct)
            begin
                add_sample(OP_POLL, RAW_W'($urandom()), $urandom());
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    gen_ms = $urandom();
                else if (r < 9)
                    gen_ms = gen_ms + $urandom_range(1, jump_max);
                else
                    gen_ms = gen_ms + $urandom_range(0, step_max);
                r = $urandom_range(0, 99);
                raw = hold_raw;
                if (r < 8)
                begin
                    hold_raw = hold_raw ^ (8'd1 << $urandom_range(0, 7));
                    raw = hold_raw;
                end
                else if (r < 14)
                    raw = hold_raw ^ (8'd1 << $urandom_range(0, 7));
                else if (r < 18)
                    raw = RAW_W'($urandom());
                add_sample(OP_TICK, raw, gen_ms);
            end
        end
    endtask

    task automatic settle;
        while (beats_left != 0 || due_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEBOUNCE)
            settle_window = val;
        else if (idx == CFG_LONG_PRESS)
            hold_window = val;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty poll, all pressed, long press with overflow, release
        add_sample(OP_POLL, 8'hFF, 32'hFFFF_FFFF);
        add_sample(OP_TICK, 8'hFF, 32'd0);
        add_sample(OP_TICK, 8'hFF, 32'd49);
        add_sample(OP_TICK, 8'hFF, 32'd50);
        add_sample(OP_TICK, 8'hFF, 32'd1050);
        add_sample(OP_TICK, 8'h00, 32'd1060);
        add_sample(OP_TICK, 8'h00, 32'd1110);
        add_sample(OP_POLL, 8'h00, 32'd0);
        add_sample(OP_POLL, 8'hA5, 32'h5A5A_5A5A);
        // press and short press across the time wrap
        add_sample(OP_TICK, 8'h01, 32'hFFFF_FFF0);
        add_sample(OP_TICK, 8'h01, 32'h0000_0022);
        add_sample(OP_TICK, 8'h00, 32'h0000_0030);
        add_sample(OP_TICK, 8'h00, 32'h0000_0062);
        add_sample(OP_POLL, 8'h00, 32'd0);
        add_sample(OP_POLL, 8'h00, 32'd0);
        gen_ms = 32'h0000_0062;
        add_random(60, 20, 20, 2000);
        settle();

        // zero times: stable and long press on the same tick
        cfg_write(CFG_DEBOUNCE, 16'd0);
        cfg_write(CFG_LONG_PRESS, 16'd0);
        cfg_write(CFG_SPARE_A, CFG_W'($urandom()));
        cfg_write(CFG_SPARE_B, 16'hFFFF);
        add_sample(OP_TICK, 8'h81, gen_ms + 1);
        add_sample(OP_TICK, 8'h00, gen_ms + 2);
        add_sample(OP_POLL, 8'h00, 32'd0);
        gen_ms = gen_ms + 2;
        hold_raw = 8'h00;
        add_random(50, 30, 2, 50);
        settle();

        cfg_write(CFG_DEBOUNCE, 16'd3);
        cfg_write(CFG_LONG_PRESS, 16'd12);
        add_random(110, 25, 3, 60);
        settle();

        // rare polls so the event ring overflows
        cfg_write(CFG_DEBOUNCE, 16'd5);
        cfg_write(CFG_LONG_PRESS, 16'd20);
        add_random(80, 5, 3, 80);
        settle();

        cfg_write(CFG_DEBOUNCE, 16'hFFFF);
        cfg_write(CFG_LONG_PRESS, 16'hFFFF);
        add_random(50, 25, 30000, 200000);
        settle();

        cfg_write(CFG_DEBOUNCE, 16'd1);
        cfg_write(CFG_LONG_PRESS, 16'd400);
        add_random(50, 40, 40, 1000);
        settle();

        cfg_write(CFG_DEBOUNCE, 16'd2);
        cfg_write(CFG_LONG_PRESS, 16'd8);
        add_random(70, 25, 2, 30);
        settle();

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
